// ===== src/vsc_pkg.sv =====
// Shared types, constants and helpers for the Verlet step with speed clamp.
// No dependencies; every other file of the block but vsc_if imports this package.
package vsc_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAG_W       = 31;
  localparam int SQ_W        = 2 * MAG_W;

  localparam logic signed [31:0] GRAVITY_RST = 32'sd0;
  localparam logic [15:0]        STEP_RST    = 16'd137;
  localparam logic [MAG_W-1:0]   LIMIT_RST   = 31'd655360;
  localparam logic [SQ_W-1:0]    LIMIT_SQ_RST = 62'd429496729600;
  localparam logic [31:0]        STEP_SQ_RST = 32'd18769;

  typedef enum logic [1:0] {
    REG_GRAVITY = 2'd0,
    REG_STEP    = 2'd1,
    REG_LIMIT   = 2'd2
  } vsc_reg_t;

  // One classified particle between front and back end.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               sx;
    logic               sy;
    logic [MAG_W-1:0]   ax;
    logic [MAG_W-1:0]   ay;
    logic [SQ_W:0]      norm;
    logic               clamp;
  } vsc_job_t;

  // Values derived from the configuration registers.
  typedef struct packed {
    logic [MAG_W-1:0]   lim;
    logic [SQ_W-1:0]    lim_sq;
    logic signed [32:0] grav_term;
  } vsc_coef_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== src/vsc_if.sv =====
// Valid/ready channel interfaces for particle items and result items.
// Depends on nothing.
interface vsc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  modport source (output valid, pos_x, pos_y, prev_x, prev_y, input ready);
  modport sink   (input valid, pos_x, pos_y, prev_x, prev_y, output ready);
endinterface

interface vsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] next_x;
  logic signed [31:0] next_y;
  logic               was_clamped;
  modport source (output valid, next_x, next_y, was_clamped, input ready);
  modport sink   (input valid, next_x, next_y, was_clamped, output ready);
endinterface

// ===== src/vsc_front.sv =====
// Front end: takes particle items, forms the motion and classifies it as
// clamped or free. Depends on vsc_pkg and vsc_if.
module vsc_front import vsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  vsc_in_if.sink            items,
  input  logic [SQ_W-1:0]   lim_sq,
  output vsc_job_t          job,
  output logic              job_valid,
  input  logic              job_ready
);

  logic               v1, v2, en;
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  logic               big_c;
  logic signed [31:0] px1, py1, px2, py2;
  logic               sx1, sy1, sx2, sy2, big1, big2;
  logic [MAG_W-1:0]   ax1, ay1, ax2, ay2;
  logic [SQ_W-1:0]    sa, sb;
  logic [SQ_W:0]      norm;

  // advance the whole pipe unless the last stage is blocked
  assign en = !v2 || job_ready;
  assign items.ready = en;

  assign dx = {items.pos_x[31], items.pos_x} - {items.prev_x[31], items.prev_x};
  assign dy = {items.pos_y[31], items.pos_y} - {items.prev_y[31], items.prev_y};
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign big_c = (adx[32:31] != 2'b00) || (ady[32:31] != 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= items.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1  <= items.pos_x;
      py1  <= items.pos_y;
      sx1  <= dx[32];
      sy1  <= dy[32];
      big1 <= big_c;
      ax1  <= big_c ? adx[31:1] : adx[30:0];
      ay1  <= big_c ? ady[31:1] : ady[30:0];
      px2  <= px1;
      py2  <= py1;
      sx2  <= sx1;
      sy2  <= sy1;
      big2 <= big1;
      ax2  <= ax1;
      ay2  <= ay1;
      sa   <= SQ_W'(ax1) * SQ_W'(ax1);
      sb   <= SQ_W'(ay1) * SQ_W'(ay1);
    end
  end

  assign norm = {1'b0, sa} + {1'b0, sb};

  always_comb begin
    job.px    = px2;
    job.py    = py2;
    job.sx    = sx2;
    job.sy    = sy2;
    job.ax    = ax2;
    job.ay    = ay2;
    job.norm  = norm;
    job.clamp = big2 || (norm > {1'b0, lim_sq});
  end
  assign job_valid = v2;

endmodule

// ===== src/vsc_queue.sv =====
// Short first-in first-out queue of classified jobs between front and back.
// Depends on vsc_pkg.
module vsc_queue import vsc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  vsc_job_t wr_data,
  input  logic     wr_valid,
  output logic     wr_ready,
  output vsc_job_t rd_data,
  output logic     rd_valid,
  input  logic     rd_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vsc_job_t        slots [DEPTH];
  logic [PW-1:0]   wp, rp;
  logic [CW-1:0]   count;
  logic            push, pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;
  assign rd_data = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("queue lost a push");
  a_count_dn: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1) else $error("queue lost a pop");

endmodule

// ===== src/vsc_back.sv =====
// Back end: rescales clamped motion with a bit-serial square root and two
// restoring dividers, then forms the saturated sums. Depends on vsc_pkg, vsc_if.
module vsc_back import vsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  vsc_job_t  job,
  input  logic      job_valid,
  output logic      job_ready,
  input  vsc_coef_t coef,
  vsc_out_if.source res
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROOT = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } st_t;

  st_t                state;
  logic signed [31:0] w_px, w_py;
  logic               w_sx, w_sy;
  logic [63:0]        rad;
  logic [33:0]        rem;
  logic [35:0]        rem_t, trial;
  logic [31:0]        root;
  logic [4:0]         cnt;
  logic [SQ_W-1:0]    pa, pb;
  logic [31:0]        ra, rb;
  logic [32:0]        ta, tb;
  logic [MAG_W-1:0]   qa, qb;
  logic               oval, ocl, out_free, sel_done, load_out;
  logic signed [31:0] onx, ony;
  logic signed [31:0] c_px, c_py;
  logic               c_sx, c_sy;
  logic [MAG_W-1:0]   c_ax, c_ay;
  logic signed [34:0] ex, ey, sum_x, sum_y;

  assign out_free  = !oval || res.ready;
  assign job_ready = (state == ST_IDLE) && job_valid && (job.clamp || out_free);
  assign sel_done  = (state == ST_DONE);
  assign load_out  = out_free && (sel_done ||
                     ((state == ST_IDLE) && job_valid && !job.clamp));

  // one root digit per cycle
  assign rem_t = {rem, rad[63:62]};
  assign trial = {2'b00, root, 2'b01};
  // one quotient bit per cycle on each axis
  assign ta = {ra, qa[MAG_W-1]};
  assign tb = {rb, qb[MAG_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (job_ready && job.clamp) state <= ST_ROOT;
        ST_ROOT: if (cnt == 5'd31) state <= ST_DIV;
        ST_DIV:  if (cnt == 5'(MAG_W - 1)) state <= ST_DONE;
        ST_DONE: if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        w_px <= job.px;
        w_py <= job.py;
        w_sx <= job.sx;
        w_sy <= job.sy;
        rad  <= {1'b0, job.norm};
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        pa   <= SQ_W'(job.ax) * SQ_W'(coef.lim);
        pb   <= SQ_W'(job.ay) * SQ_W'(coef.lim);
      end
      ST_ROOT: begin
        if (rem_t >= trial) begin
          rem  <= 34'(rem_t - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_t[33:0];
          root <= {root[30:0], 1'b0};
        end
        rad <= {rad[61:0], 2'b00};
        cnt <= (cnt == 5'd31) ? '0 : cnt + 1'b1;
        ra  <= 32'(pa[SQ_W-1:MAG_W]);
        rb  <= 32'(pb[SQ_W-1:MAG_W]);
        qa  <= pa[MAG_W-1:0];
        qb  <= pb[MAG_W-1:0];
      end
      ST_DIV: begin
        if (ta >= {1'b0, root}) begin
          ra <= 32'(ta - {1'b0, root});
          qa <= {qa[MAG_W-2:0], 1'b1};
        end else begin
          ra <= ta[31:0];
          qa <= {qa[MAG_W-2:0], 1'b0};
        end
        if (tb >= {1'b0, root}) begin
          rb <= 32'(tb - {1'b0, root});
          qb <= {qb[MAG_W-2:0], 1'b1};
        end else begin
          rb <= tb[31:0];
          qb <= {qb[MAG_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  assign c_px = sel_done ? w_px : job.px;
  assign c_py = sel_done ? w_py : job.py;
  assign c_sx = sel_done ? w_sx : job.sx;
  assign c_sy = sel_done ? w_sy : job.sy;
  assign c_ax = sel_done ? qa : job.ax;
  assign c_ay = sel_done ? qb : job.ay;
  assign ex = c_sx ? -$signed({4'b0, c_ax}) : $signed({4'b0, c_ax});
  assign ey = c_sy ? -$signed({4'b0, c_ay}) : $signed({4'b0, c_ay});
  assign sum_x = {{3{c_px[31]}}, c_px} + ex;
  assign sum_y = {{3{c_py[31]}}, c_py} + ey + {{2{coef.grav_term[32]}}, coef.grav_term};

  always_ff @(posedge clk) begin
    if (rst) begin
      oval <= 1'b0;
    end else if (out_free) begin
      oval <= load_out;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      onx <= sat32(sum_x);
      ony <= sat32(sum_y);
      ocl <= sel_done;
    end
  end

  assign res.valid       = oval;
  assign res.next_x      = onx;
  assign res.next_y      = ony;
  assign res.was_clamped = ocl;

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> root != '0) else $error("divide by zero root");
  a_within_limit: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> qa <= coef.lim && qb <= coef.lim)
    else $error("rescaled motion beyond limit");
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_free |=> oval && ocl)
    else $error("clamped result not delivered");

endmodule

// ===== src/verlet_step_with_speed_clamp_unit.sv =====
// Top level of the Verlet step with speed clamp: APB registers, coefficient
// precompute, front end, queue and back end. Depends on vsc_pkg and vsc_if.
//
// Each particle item gives one result item in order. An item whose motion is
// within the limit passes at one item per clock while the result channel is
// ready and no clamp holds the back end. An item that needs clamping holds the
// back end while it loads and forms motion times limit, runs the
// one-bit-per-cycle square root and the two shared-divisor restoring dividers,
// then presents the result. The front end keeps accepting into a four-entry
// queue meanwhile. The squared limit is registered from the limit, and gravity
// times step time squared is formed through registered step squared, product
// and rounded term after a write; registers at byte offsets 0, 4 and 8.
module verlet_step_with_speed_clamp_unit import vsc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  vsc_in_if.sink      particle,
  vsc_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [31:0] gravity;
  logic [15:0]        step;
  logic [MAG_W-1:0]   lim;
  logic [SQ_W-1:0]    lim_sq;
  logic [31:0]        step_sq;
  logic [63:0]        gprod;
  logic [31:0]        gmag;
  logic               gneg;
  logic [32:0]        gr;
  logic signed [32:0] grav_term;
  vsc_reg_t           idx;
  vsc_coef_t          coef;
  vsc_job_t           f_job, q_job;
  logic               f_valid, f_ready, q_valid, q_ready;

  assign pready = 1'b1;
  assign idx = vsc_reg_t'(paddr[3:2]);

  // write at the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= GRAVITY_RST;
      step    <= STEP_RST;
      lim     <= LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_GRAVITY: gravity <= pwdata;
        REG_STEP:    step    <= pwdata[15:0];
        REG_LIMIT:   lim     <= pwdata[MAG_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GRAVITY: prdata = gravity;
      REG_STEP:    prdata = {16'b0, step};
      REG_LIMIT:   prdata = {1'b0, lim};
      default:     prdata = '0;
    endcase
  end

  // gravity term: round |g| * t^2 >> 32 to nearest, ties away from zero
  assign gneg = gravity[31];
  assign gmag = gneg ? 32'(-{gravity[31], gravity}) : gravity;
  assign gr   = {1'b0, gprod[63:32]} + 33'(gprod[31]);

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_sq    <= LIMIT_SQ_RST;
      step_sq   <= STEP_SQ_RST;
      gprod     <= '0;
      grav_term <= '0;
    end else begin
      lim_sq    <= SQ_W'(lim) * SQ_W'(lim);
      step_sq   <= 32'(step) * 32'(step);
      gprod     <= 64'(gmag) * 64'(step_sq);
      grav_term <= gneg ? -$signed(gr) : $signed(gr);
    end
  end

  assign coef.lim       = lim;
  assign coef.lim_sq    = lim_sq;
  assign coef.grav_term = grav_term;

  vsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (particle),
    .lim_sq    (lim_sq),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  vsc_queue #(.DEPTH(DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (f_job),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_data  (q_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  vsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_job),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .coef      (coef),
    .res       (result)
  );

endmodule

// ===== sim/vsc_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the Verlet step with speed clamp: watches both channels,
// predicts each result from its own copy of the registers. Depends on vsc_pkg, vsc_if.
module vsc_checker import vsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  vsc_in_if.sink     particle,
  vsc_out_if.sink    result,
  input  logic       cfg_we,
  input  vsc_reg_t   cfg_idx,
  input  logic [31:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         clamp_seen
);

  typedef struct {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic               clamped;
  } step_t;

  step_t step_q[$];
  logic signed [31:0] grav;
  logic [15:0]        tstep;
  logic [30:0]        limit;

  assign pending = step_q.size();

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic step_t predict_step(input logic signed [31:0] px, py, qx, qy);
    step_t s;
    longint mx, my, gt;
    logic [63:0] a, b, lim, root_len, gm, t2, p, r;
    logic clamp;
    mx = longint'(px) - longint'(qx);
    my = longint'(py) - longint'(qy);
    a = mx < 0 ? -mx : mx;
    b = my < 0 ? -my : my;
    lim = limit;
    if (a >= 64'h8000_0000 || b >= 64'h8000_0000) begin
      clamp = 1;
      a = a >> 1;
      b = b >> 1;
    end else begin
      clamp = (a * a + b * b) > lim * lim;
    end
    if (clamp) begin
      root_len = int_sqrt(a * a + b * b);
      if (root_len == 0) root_len = 1;
      mx = mx < 0 ? -longint'((a * lim) / root_len) : longint'((a * lim) / root_len);
      my = my < 0 ? -longint'((b * lim) / root_len) : longint'((b * lim) / root_len);
    end
    gm = grav < 0 ? -longint'(grav) : longint'(grav);
    t2 = tstep * tstep;
    p = gm * t2;
    r = (p >> 32) + ((p >> 31) & 1);
    gt = grav < 0 ? -longint'(r) : longint'(r);
    s.nx = clip32(longint'(px) + mx);
    s.ny = clip32(longint'(py) + my + gt);
    s.clamped = clamp;
    return s;
  endfunction

  task automatic report(input string what, input logic [31:0] got, want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    step_t want;
    if (rst) begin
      grav <= GRAVITY_RST;
      tstep <= STEP_RST;
      limit <= LIMIT_RST;
      fail_count = 0;
      clamp_seen <= 0;
      step_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_GRAVITY: grav <= cfg_data;
          REG_STEP:    tstep <= cfg_data[15:0];
          REG_LIMIT:   limit <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (particle.valid && particle.ready)
        step_q.insert(step_q.size(), predict_step(particle.pos_x, particle.pos_y,
                                                  particle.prev_x, particle.prev_y));
      if (result.valid && result.ready) begin
        if (step_q.size() == 0) begin
          report("unexpected item", result.next_x, '0);
        end else begin
          want = step_q.pop_front();
          if (result.next_x !== want.nx) report("next_x", result.next_x, want.nx);
          if (result.next_y !== want.ny) report("next_y", result.next_y, want.ny);
          if (result.was_clamped !== want.clamped)
            report("was_clamped", 32'(result.was_clamped), 32'(want.clamped));
          if (want.clamped) clamp_seen <= clamp_seen + 1;
        end
      end
    end
  end

endmodule

// ===== sim/verlet_step_with_speed_clamp_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the Verlet step unit: clock, reset, register writes,
// particle stimulus and verdict. Depends on vsc_pkg, vsc_if, vsc_checker and the unit.
module verlet_step_with_speed_clamp_unit_tb import vsc_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1000;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int fail_count, pending, clamp_seen;
  int cycles = 0;
  int sent = 0;
  logic stall_mode = 0;

  vsc_in_if  particle ();
  vsc_out_if result ();

  verlet_step_with_speed_clamp_unit i_dut (
    .clk, .rst, .particle(particle.sink), .result(result.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // The checker sees a register write at the same edge the block takes it.
  vsc_checker i_checker (
    .clk, .rst, .particle(particle.sink), .result(result.sink),
    .cfg_we(psel && penable && pwrite && pready),
    .cfg_idx(vsc_reg_t'(paddr[3:2])), .cfg_data(pwdata),
    .fail_count, .pending, .clamp_seen
  );

  always #5 clk = ~clk;

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver stalls: alternate between a free-flowing stretch and a choppy one.
  initial begin
    result.ready = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
      result.ready = stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  task automatic write_reg(input vsc_reg_t idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // Drive one particle item and hold it until the block takes it.
  task automatic send_item(input logic [31:0] px, py, qx, qy);
    particle.valid = 1;
    particle.pos_x = px; particle.pos_y = py;
    particle.prev_x = qx; particle.prev_y = qy;
    do @(posedge clk); while (!particle.ready);
    sent++;
    @(negedge clk);
    particle.valid = 0;
  endtask

  // Let the pipeline drain, including a clamp in flight, before touching registers.
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 40) << 14;
      default: return $urandom;
    endcase
  endfunction

  // Mostly small motions near or around the limit so the clamp decision is exercised.
  task automatic random_item();
    logic [31:0] px, py, dx, dy;
    px = rand_pos();
    py = rand_pos();
    if ($urandom_range(0, 3) == 0) begin
      send_item(px, py, rand_pos(), rand_pos());
    end else begin
      dx = $urandom_range(0, 1) ? $urandom_range(0, 1 << 21) : -$urandom_range(0, 1 << 21);
      dy = $urandom_range(0, 1) ? $urandom_range(0, 1 << 21) : -$urandom_range(0, 1 << 21);
      send_item(px, py, px - dx, py - dy);
    end
  endtask

  task automatic random_burst(input int count);
    int n;
    n = 0;
    while (n < count) begin
      repeat ($urandom_range(1, 12)) begin
        if (n < count) random_item();
        n++;
      end
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  initial begin
    particle.valid = 0;
    particle.pos_x = 0; particle.pos_y = 0;
    particle.prev_x = 0; particle.prev_y = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: zero motion, extremes, clamp boundary, largest motion.
    send_item(0, 0, 0, 0);
    send_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(32'h000a_0000, 0, 0, 0);
    send_item(32'h000a_0001, 0, 0, 0);
    send_item(32'h0006_0000, 32'h0008_0000, 0, 0);
    send_item(32'h0006_0000, 32'h0008_0001, 0, 0);
    send_item(32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff);
    send_item(32'h7fff_0000, 32'h7fff_0000, 32'h7ffe_0000, 32'h7ffe_0000);
    drain();

    // Zero limit: any nonzero motion collapses; zero motion stays unclamped.
    write_reg(REG_LIMIT, 32'h0);
    write_reg(REG_GRAVITY, 32'h7fff_ffff);
    write_reg(REG_STEP, 32'hffff_ffff);
    send_item(0, 0, 0, 0);
    send_item(5, 7, 4, 7);
    send_item(32'h7fff_ffff, 32'h7fff_fff0, 32'h7fff_fff0, 32'h7fff_fff0);
    drain();

    write_reg(REG_LIMIT, 32'hffff_ffff);
    write_reg(REG_GRAVITY, 32'h8000_0000);
    send_item(32'h8000_0000, 32'h8000_0010, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(32'h1234_5678, 32'h8000_0001, 32'h1234_0000, 32'h8000_0002);
    drain();

    // Random phases, each with its own register setting.
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(REG_GRAVITY, phase == 0 ? 32'h0 : $urandom);
      write_reg(REG_STEP, phase == 1 ? 32'h0 : $urandom);
      write_reg(REG_LIMIT, phase == 2 ? 32'h7fff_ffff : $urandom_range(0, 1 << 21));
      random_burst(RANDOM_ITEMS / 5);
      // Hold the sender until every result is back.
      drain();
    end

    $display("sent %0d particle items, %0d results clamped, over %0d cycles",
             sent, clamp_seen, cycles);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/vsc_pkg.sv
src/vsc_if.sv
src/vsc_front.sv
src/vsc_queue.sv
src/vsc_back.sv
src/verlet_step_with_speed_clamp_unit.sv
sim/vsc_checker.sv
sim/verlet_step_with_speed_clamp_unit_tb.sv
